@@ src/ipr_pkg.sv @@
// Shared constants and types for the isolated pixel removal filter.
package ipr_pkg;

	// Field and register widths
	localparam int PIX_BITS        = 8;
	localparam int CFG_WIDTH_BITS  = 9;
	localparam int CFG_HEIGHT_BITS = 13;
	localparam int APB_DATA_BITS   = 32;
	localparam int APB_ADDR_BITS   = 3;
	localparam int REG_SEL_BIT     = 2;

	// A pixel survives with at least this many nonzero neighbours
	localparam int MIN_NEIGHBOURS = 2;

	typedef enum logic [0:0] {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_type_t;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// Neighbour bounds of one emitted pixel
	typedef struct packed {
		logic has_up;
		logic has_down;
		logic has_left;
		logic has_right;
		logic first;
		logic last;
		logic unit_width;
	} nbr_ctl_t;

endpackage

@@ src/ipr_req_if.sv @@
// Input channel: pixel or drain request beats.
interface ipr_req_if;
	import ipr_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [PIX_BITS-1:0] pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

@@ src/ipr_res_if.sv @@
// Output channel: filtered pixel beats.
interface ipr_res_if;
	import ipr_pkg::*;

	logic                valid;
	logic                ready;
	logic [PIX_BITS-1:0] pixel_out;
	logic                end_of_image;

	modport source (output valid, output pixel_out, output end_of_image, input ready);
	modport sink (input valid, input pixel_out, input end_of_image, output ready);
endinterface

@@ src/ipr_cfg_regs.sv @@
// APB register file with clamped width, height and the pixel count of one image.
module ipr_cfg_regs #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          psel,
	input  logic                                          penable,
	input  logic                                          pwrite,
	input  logic [ipr_pkg::APB_ADDR_BITS-1:0]             paddr,
	input  logic [ipr_pkg::APB_DATA_BITS-1:0]             pwdata,
	output logic [ipr_pkg::APB_DATA_BITS-1:0]             prdata,
	output logic                                          pready,
	output logic [$clog2(MAX_WIDTH+1)-1:0]                eff_width,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]     pix_count
);
	import ipr_pkg::*;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int RST_W = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;

	logic [CFG_WIDTH_BITS-1:0]  width_q;
	logic [CFG_HEIGHT_BITS-1:0] height_q;
	logic [WW-1:0]              eff_w_q;
	logic [HW-1:0]              eff_h_q;
	logic [PW-1:0]              count_q;
	logic                       wr_en;
	reg_idx_t                   sel_idx;
	logic [CFG_WIDTH_BITS-1:0]  wv;
	logic [CFG_HEIGHT_BITS-1:0] hv;
	logic [WW-1:0]              wv_eff;
	logic [HW-1:0]              hv_eff;

	assign wr_en   = psel && penable && pwrite;
	assign sel_idx = reg_idx_t'(paddr[REG_SEL_BIT]);
	assign wv      = pwdata[CFG_WIDTH_BITS-1:0];
	assign hv      = pwdata[CFG_HEIGHT_BITS-1:0];
	assign pready  = 1'b1;

	// Clamp written values to the supported range, zero counts as one
	always_comb begin
		if (wv == '0) begin
			wv_eff = WW'(1);
		end else if (32'(wv) > 32'(MAX_WIDTH)) begin
			wv_eff = WW'(MAX_WIDTH);
		end else begin
			wv_eff = WW'(wv);
		end
		if (hv == '0) begin
			hv_eff = HW'(1);
		end else if (32'(hv) > 32'(MAX_HEIGHT)) begin
			hv_eff = HW'(MAX_HEIGHT);
		end else begin
			hv_eff = HW'(hv);
		end
	end

	// Capture writes and refresh the pixel count with the new dimension
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_WIDTH_BITS'(256);
			height_q <= CFG_HEIGHT_BITS'(1);
			eff_w_q  <= WW'(RST_W);
			eff_h_q  <= HW'(1);
			count_q  <= PW'(RST_W);
		end else if (wr_en) begin
			case (sel_idx)
				REG_IMAGE_WIDTH: begin
					width_q <= wv;
					eff_w_q <= wv_eff;
					count_q <= PW'(PW'(wv_eff) * PW'(eff_h_q));
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= hv;
					eff_h_q  <= hv_eff;
					count_q  <= PW'(PW'(eff_w_q) * PW'(hv_eff));
				end
				default: begin
				end
			endcase
		end
	end

	// Read back the raw register values
	always_comb begin
		case (sel_idx)
			REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign eff_width = eff_w_q;
	assign pix_count = count_q;
endmodule

@@ src/ipr_raw_win.sv @@
// Window memory of raw pixels: one write port, two registered read ports.
module ipr_raw_win #(
	parameter int DEPTH = 257
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [$clog2(DEPTH)-1:0]        wr_addr,
	input  logic [ipr_pkg::PIX_BITS-1:0]    wr_data,
	input  logic                            rd_en,
	input  logic [$clog2(DEPTH)-1:0]        rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]        rd_addr_b,
	output logic [ipr_pkg::PIX_BITS-1:0]    rd_data_a,
	output logic [ipr_pkg::PIX_BITS-1:0]    rd_data_b
);
	import ipr_pkg::*;

	logic [PIX_BITS-1:0] mem [DEPTH];

	// Store the incoming raw pixel
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read both neighbours, forward a pixel written in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
			rd_data_b <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
		end
	end
endmodule

@@ src/ipr_flag_row.sv @@
// One row of nonzero flags of filtered pixels, one write and one registered read.
module ipr_flag_row #(
	parameter int DEPTH = 256
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic                                         wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic                                         rd_data
);
	logic mem [DEPTH];

	// Store the flag of the pixel just filtered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Fetch the flag of the pixel one row up
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

@@ src/isolated_pixel_removal_filter_core.sv @@
// Streaming 4-neighbour despeckle: pixels enter in raster order, one beat per cycle when not stalled, and
// pixel i leaves once pixel i+image_width has entered (drain beats release the last row).
// Throughput is one input beat per clock while the output is not stalled; a released pixel
// goes through the memory read, the neighbour count and the output register. The rate rests
// on the raw window memory, whose two read ports fetch the right and down neighbours in the
// same cycle as the new pixel is written; up and left flags come from a one-row flag memory
// and a register. There is no clearing pass after reset. Reprogram width and height only
// while no beat is in flight.
module isolated_pixel_removal_filter_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ipr_req_if.sink                            req,
	ipr_res_if.source                          res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ipr_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [ipr_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [ipr_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);
	import ipr_pkg::*;

	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int PW        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int WIN_DEPTH = MAX_WIDTH + 1;
	localparam int AW        = $clog2(WIN_DEPTH);
	localparam int FW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// Configuration
	logic [WW-1:0] eff_w;
	logic [PW-1:0] pix_cnt;

	// Positions and their memory addresses
	logic [PW-1:0] in_pos_q;
	logic [PW-1:0] out_pos_q;
	logic [AW-1:0] in_addr_q;
	logic [AW-1:0] out_addr_q;
	logic [FW-1:0] out_faddr_q;

	// Accept stage
	logic          in_fire;
	logic          restart;
	logic [PW-1:0] in_p;
	logic [PW-1:0] out_p;
	logic [AW-1:0] in_addr_p;
	logic [AW-1:0] out_addr_p;
	logic [FW-1:0] out_faddr_p;
	logic          is_drain;
	logic          px_ok;
	logic          emit;
	logic [PW:0]   out_p_x;
	logic [PW:0]   down_pos;
	logic [AW-1:0] in_addr_nx;
	logic [AW-1:0] right_addr;
	logic [AW:0]   down_sum;
	logic [AW-1:0] down_addr;
	logic [FW:0]   up_diff;
	logic [FW-1:0] up_faddr;
	logic [FW-1:0] faddr_nx;
	nbr_ctl_t      ctl_d;

	// Compute stage
	logic                s1_valid_s1;
	nbr_ctl_t            ctl_s1;
	logic [FW-1:0]       faddr_s1;
	logic                s1_adv;
	logic [PIX_BITS-1:0] raw_right;
	logic [PIX_BITS-1:0] raw_down;
	logic                flag_up;
	logic [PIX_BITS-1:0] raw_self;
	logic                nb_up;
	logic                nb_down;
	logic                nb_left;
	logic                nb_right;
	logic [2:0]          nb_cnt;
	logic [PIX_BITS-1:0] value;
	logic [PIX_BITS-1:0] first_raw_q;
	logic [PIX_BITS-1:0] next_raw_q;
	logic                last_flag_q;

	// Output register
	logic                res_valid_q;
	logic [PIX_BITS-1:0] pix_q;
	logic                eoi_q;

	ipr_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.eff_width (eff_w),
		.pix_count (pix_cnt)
	);

	// Accept a beat while the compute stage is free or moving on
	assign req.ready = !s1_valid_s1 || !res_valid_q || res.ready;
	assign in_fire   = req.valid && req.ready;

	// Restart both positions once the output count no longer fits the image
	assign restart     = (out_pos_q >= pix_cnt);
	assign in_p        = restart ? '0 : in_pos_q;
	assign out_p       = restart ? '0 : out_pos_q;
	assign in_addr_p   = restart ? '0 : in_addr_q;
	assign out_addr_p  = restart ? '0 : out_addr_q;
	assign out_faddr_p = restart ? '0 : out_faddr_q;

	assign is_drain = (req.req_type == REQ_DRAIN);
	assign px_ok    = !is_drain && (in_p < pix_cnt);
	assign out_p_x  = {1'b0, out_p};
	assign down_pos = out_p_x + (PW+1)'(eff_w);

	// Decide whether this beat releases the pixel at the output position
	always_comb begin
		if (is_drain) begin
			emit = (in_p >= pix_cnt) && (out_p < pix_cnt);
		end else begin
			emit = px_ok && (down_pos <= {1'b0, in_p});
		end
	end

	// Neighbour bounds of the released pixel
	always_comb begin
		ctl_d.has_up     = (out_p >= PW'(eff_w));
		ctl_d.has_down   = (down_pos < {1'b0, pix_cnt});
		ctl_d.has_left   = (out_p != '0);
		ctl_d.has_right  = ((out_p_x + (PW+1)'(1)) < {1'b0, pix_cnt});
		ctl_d.first      = (out_p == '0);
		ctl_d.last       = ((out_p_x + (PW+1)'(1)) == {1'b0, pix_cnt});
		ctl_d.unit_width = (eff_w == WW'(1));
	end

	// Window addresses wrap at the window depth, flag addresses at the maximum row width
	assign in_addr_nx = (in_addr_p == AW'(WIN_DEPTH - 1)) ? '0 : in_addr_p + AW'(1);
	assign right_addr = (out_addr_p == AW'(WIN_DEPTH - 1)) ? '0 : out_addr_p + AW'(1);
	assign down_sum   = {1'b0, out_addr_p} + (AW+1)'(eff_w);
	assign down_addr  = (down_sum >= (AW+1)'(WIN_DEPTH)) ?
		AW'(down_sum - (AW+1)'(WIN_DEPTH)) : AW'(down_sum);
	assign up_diff    = {1'b0, out_faddr_p} - (FW+1)'(eff_w);
	assign up_faddr   = up_diff[FW] ? FW'(up_diff + (FW+1)'(MAX_WIDTH)) : FW'(up_diff);
	assign faddr_nx   = (out_faddr_p == FW'(MAX_WIDTH - 1)) ? '0 : out_faddr_p + FW'(1);

	ipr_raw_win #(
		.DEPTH (WIN_DEPTH)
	) u_raw_win (
		.clk       (clk),
		.wr_en     (in_fire && px_ok),
		.wr_addr   (in_addr_p),
		.wr_data   (req.pixel_in),
		.rd_en     (in_fire && emit),
		.rd_addr_a (right_addr),
		.rd_addr_b (down_addr),
		.rd_data_a (raw_right),
		.rd_data_b (raw_down)
	);

	ipr_flag_row #(
		.DEPTH (MAX_WIDTH)
	) u_flag_row (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (faddr_s1),
		.wr_data (value != '0),
		.rd_en   (in_fire && emit),
		.rd_addr (up_faddr),
		.rd_data (flag_up)
	);

	// Advance positions; drop both to zero after the last pixel of the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q    <= '0;
			out_pos_q   <= '0;
			in_addr_q   <= '0;
			out_addr_q  <= '0;
			out_faddr_q <= '0;
		end else if (in_fire) begin
			if (emit && ctl_d.last) begin
				in_pos_q    <= '0;
				out_pos_q   <= '0;
				in_addr_q   <= '0;
				out_addr_q  <= '0;
				out_faddr_q <= '0;
			end else begin
				in_pos_q    <= px_ok ? in_p + PW'(1) : in_p;
				in_addr_q   <= px_ok ? in_addr_nx : in_addr_p;
				out_pos_q   <= emit ? out_p + PW'(1) : out_p;
				out_addr_q  <= emit ? right_addr : out_addr_p;
				out_faddr_q <= emit ? faddr_nx : out_faddr_p;
			end
		end
	end

	// Hold the first pixel of the image, the later ones come from the right-neighbour read
	always_ff @(posedge clk) begin
		if (in_fire && px_ok && (in_p == '0)) begin
			first_raw_q <= req.pixel_in;
		end
	end

	// Compute stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= emit;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			ctl_s1   <= ctl_d;
			faddr_s1 <= out_faddr_p;
		end
	end

	// Count nonzero neighbours; up comes from the left flag when rows are one pixel wide
	assign raw_self = ctl_s1.first ? first_raw_q : next_raw_q;
	assign nb_up    = ctl_s1.has_up && (ctl_s1.unit_width ? last_flag_q : flag_up);
	assign nb_down  = ctl_s1.has_down && (raw_down != '0);
	assign nb_left  = ctl_s1.has_left && last_flag_q;
	assign nb_right = ctl_s1.has_right && (raw_right != '0);
	assign nb_cnt   = 3'(nb_up) + 3'(nb_down) + 3'(nb_left) + 3'(nb_right);
	assign value    = (nb_cnt < 3'(MIN_NEIGHBOURS)) ? '0 : raw_self;

	assign s1_adv = s1_valid_s1 && (!res_valid_q || res.ready);

	// Keep the flag and the right neighbour for the next pixel, and load the output beat
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			last_flag_q <= (value != '0);
			next_raw_q  <= raw_right;
			pix_q       <= value;
			eoi_q       <= ctl_s1.last;
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.pixel_out    = pix_q;
	assign res.end_of_image = eoi_q;

`ifndef ASSERT_OFF
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && res_valid_q && !res.ready |-> !req.ready)
		else $error("input accepted while compute stage is stalled");
	a_out_behind_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_pos_q <= in_pos_q)
		else $error("output position ahead of input position");
	a_image_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && emit && ctl_d.last |=> (out_pos_q == '0) && (in_pos_q == '0))
		else $error("positions not cleared after last pixel");
	a_window_addr: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, in_addr_q} < (AW+1)'(WIN_DEPTH)) && ({1'b0, out_addr_q} < (AW+1)'(WIN_DEPTH)))
		else $error("window address out of range");
`endif
endmodule

@@ sim/ipr_despeckle_checker.sv @@
// Checker for the despeckle filter: tracks register writes and input beats, predicts and compares.
module ipr_despeckle_checker
	import ipr_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	ipr_req_if                       req,
	ipr_res_if                       res,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	input  logic [APB_DATA_BITS-1:0] prdata,
	output int                       mismatches,
	output int                       pixels_owed
);

	localparam int WIN_DEPTH = MAX_WIDTH + 1;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel;
		logic                last;
	} pix_beat_t;

	// Shadow registers and filter state
	logic [CFG_WIDTH_BITS-1:0]  cfg_width;
	logic [CFG_HEIGHT_BITS-1:0] cfg_height;
	logic [PIX_BITS-1:0]        raw_win [WIN_DEPTH];
	bit                         filt_row [MAX_WIDTH];
	int unsigned                in_pos;
	int unsigned                out_pos;
	pix_beat_t                  pending_pixels [$];

	function automatic void report(string what, logic [APB_DATA_BITS-1:0] want,
			logic [APB_DATA_BITS-1:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
	endfunction

	// Filter the pixel at the output position and queue it as the next expected beat
	function automatic void release_pixel(int unsigned w, int unsigned size);
		int unsigned         i;
		int unsigned         votes;
		logic [PIX_BITS-1:0] val;
		pix_beat_t           beat;
		i = out_pos;
		votes = 0;
		val = raw_win[i % WIN_DEPTH];
		// Up and left are already filtered, down and right are raw
		if (i >= w && filt_row[(i - w) % MAX_WIDTH]) votes++;
		if (i + w < size && raw_win[(i + w) % WIN_DEPTH] != '0) votes++;
		if (i >= 1 && filt_row[(i - 1) % MAX_WIDTH]) votes++;
		if (i + 1 < size && raw_win[(i + 1) % WIN_DEPTH] != '0) votes++;
		if (votes < MIN_NEIGHBOURS) val = '0;
		filt_row[i % MAX_WIDTH] = (val != '0);
		beat.pixel = val;
		beat.last = (i + 1 == size);
		pending_pixels.push_back(beat);
		out_pos = i + 1;
		if (out_pos >= size) begin
			in_pos = 0;
			out_pos = 0;
		end
	endfunction

	// Advance the filter by one accepted request beat
	function automatic void filter_beat(req_type_t kind, logic [PIX_BITS-1:0] pix);
		int unsigned w;
		int unsigned size;
		w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
		size = w * ((cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
		// A geometry change can leave the image already complete: restart it
		if (out_pos >= size) begin
			in_pos = 0;
			out_pos = 0;
		end
		if (kind == REQ_PIXEL) begin
			if (in_pos < size) begin
				raw_win[in_pos % WIN_DEPTH] = pix;
				in_pos++;
				if (out_pos + w < in_pos) release_pixel(w, size);
			end
		end else if (in_pos >= size && out_pos < size) begin
			release_pixel(w, size);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_beat_t                want;
		logic [APB_DATA_BITS-1:0] reg_val;
		if (!arst_n) begin
			cfg_width = CFG_WIDTH_BITS'(256);
			cfg_height = CFG_HEIGHT_BITS'(1);
			in_pos = 0;
			out_pos = 0;
			pending_pixels.delete();
			mismatches = 0;
			for (int n = 0; n < WIN_DEPTH; n++) raw_win[n] = '0;
			for (int n = 0; n < MAX_WIDTH; n++) filt_row[n] = 1'b0;
		end else begin
			// Register port: update the shadow copy on writes, check reads against it
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[REG_SEL_BIT]))
						REG_IMAGE_WIDTH:  cfg_width = pwdata[CFG_WIDTH_BITS-1:0];
						REG_IMAGE_HEIGHT: cfg_height = pwdata[CFG_HEIGHT_BITS-1:0];
						default: begin
						end
					endcase
				end else begin
					if (reg_idx_t'(paddr[REG_SEL_BIT]) == REG_IMAGE_WIDTH)
						reg_val = APB_DATA_BITS'(cfg_width);
					else
						reg_val = APB_DATA_BITS'(cfg_height);
					if (prdata !== reg_val) report("prdata", reg_val, prdata);
				end
			end
			// Input beat
			if (req.valid && req.ready) filter_beat(req_type_t'(req.req_type), req.pixel_in);
			// Output beat
			if (res.valid && res.ready) begin
				if (pending_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: result beat mismatch, expected none actual %0h/%0b",
						$time, res.pixel_out, res.end_of_image);
				end else begin
					want = pending_pixels.pop_front();
					if (res.pixel_out !== want.pixel)
						report("pixel_out", APB_DATA_BITS'(want.pixel),
							APB_DATA_BITS'(res.pixel_out));
					if (res.end_of_image !== want.last)
						report("end_of_image", APB_DATA_BITS'(want.last),
							APB_DATA_BITS'(res.end_of_image));
				end
			end
		end
		pixels_owed = pending_pixels.size();
	end

endmodule

@@ sim/tb_isolated_pixel_removal_filter_core.sv @@
// Testbench top for the despeckle filter: clock, reset, stimulus, back-pressure and verdict.
module tb_isolated_pixel_removal_filter_core;
	import ipr_pkg::*;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 4096;
	localparam int ITEM_TARGET = 650;
	localparam int QUIET_FROM  = 560;
	localparam int CYCLE_LIMIT = 200000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int          err_count;
	int          open_count;
	int unsigned cycle_count = 0;
	int unsigned res_stall = 0;
	int unsigned beats_sent = 0;
	bit          idle_en;

	// Small frame that exercises row wrap, corners and an isolated bright pixel
	logic [PIX_BITS-1:0] corner_pattern [9] = '{8'hFF, 8'h01, 8'h80, 8'h00, 8'hAA,
		8'h55, 8'hFF, 8'h00, 8'hFF};

	ipr_req_if req_if ();
	ipr_res_if res_if ();

	isolated_pixel_removal_filter_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ipr_despeckle_checker #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.res         (res_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.mismatches  (err_count),
		.pixels_owed (open_count)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stall the result side in short random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (res_stall != 0) begin
			res_if.ready <= 1'b0;
			res_stall <= res_stall - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			res_if.ready <= 1'b0;
			res_stall <= $urandom_range(0, 2);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		return (v == 0) ? 1 : (v > hi) ? hi : v;
	endfunction

	// Offer one beat, with an optional idle burst first, and hold it until taken
	task automatic send_beat(input req_type_t kind, input logic [PIX_BITS-1:0] pix);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.pixel_in <= pix;
		do @(posedge clk); while (!req_if.ready);
		beats_sent++;
	endtask

	// Drop valid and wait until every predicted beat is out and the pipeline is empty
	task automatic quiesce();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (open_count != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input reg_idx_t idx,
			input logic [APB_DATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_ADDR_BITS'(idx) << REG_SEL_BIT;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Program both registers while idle, sometimes with junk above the field, and read back
	task automatic set_geometry(input logic [CFG_WIDTH_BITS-1:0] wreg,
			input logic [CFG_HEIGHT_BITS-1:0] hreg);
		logic [APB_DATA_BITS-1:0] junk;
		junk = $urandom;
		if ($urandom_range(0, 2) != 0) junk = '0;
		quiesce();
		apb_xfer(1'b1, REG_IMAGE_WIDTH, {junk[APB_DATA_BITS-1:CFG_WIDTH_BITS], wreg});
		apb_xfer(1'b1, REG_IMAGE_HEIGHT, {junk[APB_DATA_BITS-1:CFG_HEIGHT_BITS], hreg});
		apb_xfer(1'b0, REG_IMAGE_WIDTH, '0);
		apb_xfer(1'b0, REG_IMAGE_HEIGHT, '0);
	endtask

	// Stream one image with random content; optionally change the height after cut pixels
	task automatic run_image(input logic [CFG_WIDTH_BITS-1:0] wreg,
			input logic [CFG_HEIGHT_BITS-1:0] hreg, input int unsigned dens,
			input int unsigned cut, input logic [CFG_HEIGHT_BITS-1:0] hnew);
		int unsigned w;
		int unsigned size;
		int unsigned fed;
		int unsigned shed;
		int unsigned new_size;
		w = clamp_dim(32'(wreg), MAX_WIDTH);
		size = w * clamp_dim(32'(hreg), MAX_HEIGHT);
		set_geometry(wreg, hreg);
		fed = 0;
		while (fed < size) begin
			if (cut != 0 && fed == cut) begin
				quiesce();
				apb_xfer(1'b1, REG_IMAGE_HEIGHT, APB_DATA_BITS'(hnew));
				new_size = w * clamp_dim(32'(hnew), MAX_HEIGHT);
				shed = (fed > w) ? fed - w : 0;
				// Everything emitted already covers the new size: the image restarts
				if (shed >= new_size) fed = 0;
				size = new_size;
				cut = 0;
				if (fed >= size) break;
			end
			// Drain before the image is complete: ignored
			if ($urandom_range(0, 39) == 0) send_beat(REQ_DRAIN, PIX_BITS'($urandom));
			send_beat(REQ_PIXEL, ($urandom_range(1, 100) <= dens) ?
				PIX_BITS'($urandom_range(1, 255)) : '0);
			fed++;
		end
		// Pixel beyond the image: ignored
		if ($urandom_range(0, 4) == 0) send_beat(REQ_PIXEL, PIX_BITS'($urandom));
		shed = (fed > w) ? fed - w : 0;
		repeat (size - shed) send_beat(REQ_DRAIN, PIX_BITS'($urandom));
		// Drain with nothing pending: ignored
		if ($urandom_range(0, 7) == 0) send_beat(REQ_DRAIN, PIX_BITS'($urandom));
	endtask

	initial begin
		int unsigned                sel;
		int unsigned                dens;
		int unsigned                cut;
		logic [CFG_WIDTH_BITS-1:0]  wreg;
		logic [CFG_HEIGHT_BITS-1:0] hreg;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_PIXEL;
		req_if.pixel_in <= '0;
		idle_en <= 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Zero registers act as one: a single-pixel image with an early drain, a surplus pixel and an idle drain
		set_geometry('0, '0);
		send_beat(REQ_DRAIN, 8'hFF);
		send_beat(REQ_PIXEL, 8'hFF);
		send_beat(REQ_PIXEL, 8'h3C);
		send_beat(REQ_DRAIN, '0);
		send_beat(REQ_DRAIN, '0);

		// 3x3 frame: row wrap of left and right, top and bottom edges
		set_geometry(CFG_WIDTH_BITS'(3), CFG_HEIGHT_BITS'(3));
		foreach (corner_pattern[n]) send_beat(REQ_PIXEL, corner_pattern[n]);
		repeat (3) send_beat(REQ_DRAIN, '0);

		// Saturated height, then shrink it mid-image below the emitted count
		run_image(CFG_WIDTH_BITS'(1), '1, 100, 4, CFG_HEIGHT_BITS'(2));

		// Saturated width, single row
		run_image('1, CFG_HEIGHT_BITS'(1), 60, 0, '0);

		// Random images, mostly small, a few wide ones
		while (beats_sent < ITEM_TARGET) begin
			idle_en <= (beats_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				wreg = CFG_WIDTH_BITS'($urandom_range(200, 511));
				hreg = CFG_HEIGHT_BITS'(1);
			end else if (sel < 8) begin
				wreg = '0;
				hreg = CFG_HEIGHT_BITS'($urandom_range(1, 8));
			end else if (sel < 25) begin
				wreg = CFG_WIDTH_BITS'($urandom_range(11, 40));
				hreg = CFG_HEIGHT_BITS'($urandom_range(0, 3));
			end else begin
				wreg = CFG_WIDTH_BITS'($urandom_range(1, 10));
				hreg = CFG_HEIGHT_BITS'($urandom_range(0, 8));
			end
			dens = 15 + 25 * $urandom_range(0, 3);
			cut = 0;
			if (clamp_dim(32'(wreg), MAX_WIDTH) * clamp_dim(32'(hreg), MAX_HEIGHT) > 2 &&
					$urandom_range(0, 7) == 0)
				cut = $urandom_range(1, clamp_dim(32'(wreg), MAX_WIDTH) *
					clamp_dim(32'(hreg), MAX_HEIGHT) - 1);
			run_image(wreg, hreg, dens, cut, CFG_HEIGHT_BITS'($urandom_range(0, 8)));
		end

		// Let everything drain out
		quiesce();
		repeat (6) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ isolated_pixel_removal_filter_core.f @@
src/ipr_pkg.sv
src/ipr_req_if.sv
src/ipr_res_if.sv
src/ipr_cfg_regs.sv
src/ipr_raw_win.sv
src/ipr_flag_row.sv
src/isolated_pixel_removal_filter_core.sv
sim/ipr_despeckle_checker.sv
sim/tb_isolated_pixel_removal_filter_core.sv
